@@ sv/crc_framed_batch_uplink_defines.svh @@
// assertion helpers
`ifndef CRC_FRAMED_BATCH_UPLINK_DEFINES_SVH
`define CRC_FRAMED_BATCH_UPLINK_DEFINES_SVH

`define CFBU_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`define CFBU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/cfbu_pkg.sv @@
package cfbu_pkg;

    typedef enum logic [1:0] {
        REQ_MSG  = 2'd0,
        REQ_HOST = 2'd1,
        REQ_TICK = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        KIND_TX    = 2'd0,
        KIND_QUEUE = 2'd1,
        KIND_DROP  = 2'd2,
        KIND_TIME  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_SYNC = 2'd1,
        MODE_ACK  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRC_RD,
        ST_CRC,
        ST_HDR,
        ST_PAY_RD,
        ST_PAY
    } bst_t;

    localparam logic [7:0]  HOST_SYNC  = 8'h11;
    localparam logic [7:0]  HOST_START = 8'h25;
    localparam logic [7:0]  HOST_ACK   = 8'h07;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    typedef struct packed {
        req_t       req;
        logic [7:0] data;
    } item_t;

    function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

@@ sv/cfbu_front.sv @@
module cfbu_front import cfbu_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_req,
    input  logic [7:0] in_data,
    output logic       q_valid,
    input  logic       q_ready,
    output item_t      q_item
);
    item_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg, wr_reg;
    logic       push, pop;

    assign in_ready = cnt_reg != 2'd2;
    assign push     = in_valid && in_ready && in_req != REQ_NONE;
    assign q_valid  = cnt_reg != 2'd0;
    assign pop      = q_valid && q_ready;
    assign q_item   = q_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) q_reg[wr_reg] <= '{req: req_t'(in_req), data: in_data};
    end
endmodule

@@ sv/cfbu_back.sv @@
module cfbu_back import cfbu_pkg::*; #(
    parameter int QUEUE_SLOTS = 16,
    parameter int MSG_BYTES   = 16,
    parameter int BATCH_MSGS  = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] timeout,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_out_kind,
    output logic [7:0]  m_tx_byte,
    output logic [31:0] m_time_first,
    output logic [31:0] m_time_second,
    output logic        m_last,
    output logic        busy
);
    localparam int SW = $clog2(QUEUE_SLOTS);
    localparam int BW = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
    localparam int DEPTH = QUEUE_SLOTS * MSG_BYTES;
    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(BATCH_MSGS * MSG_BYTES + 1);
    localparam int PW = $clog2(BATCH_MSGS * MSG_BYTES + 4);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    logic [SW-1:0] head_reg, head_next, tail_reg, tail_next, rd_slot_reg, rd_slot_next;
    logic [BW-1:0] fill_reg, fill_next, rd_byte_reg, rd_byte_next;
    logic [1:0]    cnt_reg, cnt_next, msg_reg, msg_next;
    mode_t         mode_reg, mode_next;
    logic [2:0]    sync_cnt_reg, sync_cnt_next;
    logic [63:0]   sync_reg, sync_next;
    logic [15:0]   timer_reg, timer_next, crc_reg, crc_next;
    logic [PW-1:0] pos_reg, pos_next;
    bst_t          st_reg, st_next;

    logic        ov_reg, ov_next;
    logic [1:0]  ok_reg, ok_next;
    logic [7:0]  ob_reg, ob_next;
    logic [31:0] ot1_reg, ot1_next, ot2_reg, ot2_next;
    logic        ol_reg, ol_next;
    logic        pend_reg, pend_next;

    logic          mem_we;
    logic [AW-1:0] wa, ra;
    logic [SW-1:0] head_inc, tail_inc, rd_inc;
    logic          can_out;
    logic [LW-1:0] len;

    function automatic logic [SW-1:0] inc_slot(logic [SW-1:0] s);
        return (s == SW'(QUEUE_SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [SW-1:0] dec_slot(logic [SW-1:0] s);
        return (s == '0) ? SW'(QUEUE_SLOTS - 1) : s - 1'b1;
    endfunction

    assign head_inc = inc_slot(head_reg);
    assign tail_inc = inc_slot(tail_reg);
    assign rd_inc   = inc_slot(rd_slot_reg);
    assign wa = AW'(head_reg * MSG_BYTES) + AW'(fill_reg);
    assign ra = AW'(rd_slot_reg * MSG_BYTES) + AW'(rd_byte_reg);
    assign len = LW'(msg_reg * MSG_BYTES);
    assign can_out = !ov_reg || m_ready;
    assign busy = st_reg != ST_IDLE || ov_reg || pend_reg;

    assign m_valid = ov_reg;
    assign m_out_kind = ok_reg;
    assign m_tx_byte = ob_reg;
    assign m_time_first = ot1_reg;
    assign m_time_second = ot2_reg;
    assign m_last = ol_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[wa] <= q_item.data;
        rdata_reg <= mem[ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0; tail_reg <= '0; fill_reg <= '0;
            mode_reg <= MODE_IDLE; sync_cnt_reg <= '0; sync_reg <= '0;
            timer_reg <= '0; st_reg <= ST_IDLE; ov_reg <= 1'b0; pend_reg <= 1'b0;
        end else begin
            head_reg <= head_next; tail_reg <= tail_next; fill_reg <= fill_next;
            mode_reg <= mode_next; sync_cnt_reg <= sync_cnt_next; sync_reg <= sync_next;
            timer_reg <= timer_next; st_reg <= st_next; ov_reg <= ov_next;
            pend_reg <= pend_next;
        end
        rd_slot_reg <= rd_slot_next; rd_byte_reg <= rd_byte_next;
        cnt_reg <= cnt_next; msg_reg <= msg_next; crc_reg <= crc_next; pos_reg <= pos_next;
        ok_reg <= ok_next; ob_reg <= ob_next; ot1_reg <= ot1_next; ot2_reg <= ot2_next;
        ol_reg <= ol_next;
    end

    always_comb begin
        head_next = head_reg; tail_next = tail_reg; fill_next = fill_reg;
        mode_next = mode_reg; sync_cnt_next = sync_cnt_reg; sync_next = sync_reg;
        timer_next = timer_reg; st_next = st_reg;
        rd_slot_next = rd_slot_reg; rd_byte_next = rd_byte_reg;
        cnt_next = cnt_reg; msg_next = msg_reg; crc_next = crc_reg; pos_next = pos_reg;
        ov_next = ov_reg && !m_ready; ok_next = ok_reg; ob_next = ob_reg;
        ot1_next = ot1_reg; ot2_next = ot2_reg; ol_next = ol_reg;
        pend_next = pend_reg;
        q_ready = 1'b0; mem_we = 1'b0;
        unique case (st_reg)
            ST_IDLE: begin
                if (pend_reg) begin
                    // ack byte after time set
                    if (can_out) begin
                        ov_next = 1'b1; ok_next = KIND_TX; ob_next = HOST_ACK;
                        ot1_next = '0; ot2_next = '0; ol_next = 1'b1; pend_next = 1'b0;
                    end
                end else if (can_out && q_valid) begin
                    q_ready = 1'b1;
                    case (q_item.req)
                        REQ_MSG: begin
                            mem_we = 1'b1;
                            if (fill_reg == BW'(MSG_BYTES - 1)) begin
                                fill_next = '0;
                                ov_next = 1'b1; ob_next = '0; ot1_next = '0;
                                ot2_next = '0; ol_next = 1'b1;
                                if (head_inc == tail_reg) ok_next = KIND_DROP;
                                else begin
                                    ok_next = KIND_QUEUE; head_next = head_inc;
                                end
                            end else fill_next = fill_reg + 1'b1;
                        end
                        REQ_HOST: begin
                            if (mode_reg == MODE_SYNC) begin
                                sync_next = sync_reg |
                                    ({56'd0, q_item.data} << {sync_cnt_reg, 3'b000});
                                sync_cnt_next = sync_cnt_reg + 1'b1;
                                if (sync_cnt_reg == 3'd7) begin
                                    ov_next = 1'b1; ok_next = KIND_TIME; ob_next = '0;
                                    ot1_next = sync_next[31:0]; ot2_next = sync_next[63:32];
                                    ol_next = 1'b0; pend_next = 1'b1;
                                    sync_next = '0; mode_next = MODE_IDLE;
                                end
                            end else if (mode_reg == MODE_ACK) begin
                                if (q_item.data == HOST_ACK) begin
                                    mode_next = MODE_IDLE; timer_next = '0;
                                end
                            end else if (q_item.data == HOST_SYNC) begin
                                mode_next = MODE_SYNC; sync_cnt_next = '0; sync_next = '0;
                            end else if (q_item.data == HOST_START && tail_reg != head_reg) begin
                                // count messages taken
                                if (BATCH_MSGS > 1 && tail_inc != head_reg) begin
                                    msg_next = 2'd2; tail_next = inc_slot(tail_inc);
                                end else begin
                                    msg_next = 2'd1; tail_next = tail_inc;
                                end
                                rd_slot_next = tail_reg; rd_byte_next = '0;
                                cnt_next = '0; crc_next = CRC_INIT;
                                mode_next = MODE_ACK;
                                timer_next = timeout;
                                st_next = ST_CRC_RD;
                            end
                        end
                        REQ_TICK: begin
                            if (mode_reg == MODE_ACK) begin
                                if (timer_reg <= 16'd1) begin
                                    timer_next = '0; mode_next = MODE_IDLE;
                                end else timer_next = timer_reg - 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CRC_RD: st_next = ST_CRC;
            ST_CRC: begin
                crc_next = crc_byte(crc_reg, rdata_reg);
                if (rd_byte_reg == BW'(MSG_BYTES - 1)) begin
                    rd_byte_next = '0; rd_slot_next = rd_inc; cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg + 1'b1 == msg_reg) begin
                        st_next = ST_HDR; pos_next = '0;
                        // rewind to first taken slot
                        rd_slot_next = (msg_reg == 2'd2) ? dec_slot(dec_slot(tail_reg)) :
                            dec_slot(tail_reg);
                        cnt_next = '0;
                    end else st_next = ST_CRC_RD;
                end else begin
                    rd_byte_next = rd_byte_reg + 1'b1; st_next = ST_CRC_RD;
                end
            end
            ST_HDR: begin
                if (can_out) begin
                    ov_next = 1'b1; ok_next = KIND_TX; ot1_next = '0; ot2_next = '0;
                    ol_next = 1'b0;
                    case (pos_reg[1:0])
                        2'd0: ob_next = 8'(len);
                        2'd1: ob_next = 8'(16'(len) >> 8);
                        2'd2: ob_next = crc_reg[7:0];
                        default: ob_next = crc_reg[15:8];
                    endcase
                    pos_next = pos_reg + 1'b1;
                    if (pos_reg == PW'(3)) st_next = ST_PAY_RD;
                end
            end
            ST_PAY_RD: st_next = ST_PAY;
            ST_PAY: begin
                if (can_out) begin
                    ov_next = 1'b1; ok_next = KIND_TX; ob_next = rdata_reg;
                    ot1_next = '0; ot2_next = '0; ol_next = 1'b0;
                    if (rd_byte_reg == BW'(MSG_BYTES - 1)) begin
                        rd_byte_next = '0; rd_slot_next = rd_inc; cnt_next = cnt_reg + 1'b1;
                        if (cnt_reg + 1'b1 == msg_reg) begin
                            ol_next = 1'b1; st_next = ST_IDLE;
                        end else st_next = ST_PAY_RD;
                    end else begin
                        rd_byte_next = rd_byte_reg + 1'b1; st_next = ST_PAY_RD;
                    end
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end
endmodule

@@ sv/crc_framed_batch_uplink.sv @@
// Batch uplink: message bytes fill a ring of fixed-size slots, host bytes drive
// time sync (0x11 then 8 bytes, answered 0x07) and batch transmission (0x25:
// length, CRC-16-CCITT low byte first, payload), ticks run the ack timeout.
// A two-entry input queue decouples intake from the back end. A start command
// reads the slot memory through its one registered port twice: a CRC pass over
// the payload, then, after the four header bytes, a pass that sends each byte.
`include "crc_framed_batch_uplink_defines.svh"
module crc_framed_batch_uplink import cfbu_pkg::*; #(
    parameter int QUEUE_SLOTS = 16,
    parameter int MSG_BYTES   = 16,
    parameter int BATCH_MSGS  = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_out_kind,
    output logic [7:0]  m_tx_byte,
    output logic [31:0] m_time_first,
    output logic [31:0] m_time_second,
    output logic        m_last
);
    logic [15:0] timeout_reg;
    logic        q_valid, q_ready, busy;
    item_t       q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) timeout_reg <= TIMEOUT_RESET;
        else if (cfg_we) timeout_reg <= cfg_wdata;
    end

    cfbu_front u_front (
        .aclk, .aresetn, .in_valid(s_valid), .in_ready(s_ready),
        .in_req(s_req_type), .in_data(s_data_byte),
        .q_valid, .q_ready, .q_item
    );

    cfbu_back #(.QUEUE_SLOTS(QUEUE_SLOTS), .MSG_BYTES(MSG_BYTES),
                .BATCH_MSGS(BATCH_MSGS)) u_back (
        .aclk, .aresetn, .timeout(timeout_reg), .q_valid, .q_ready, .q_item,
        .m_valid, .m_ready, .m_out_kind, .m_tx_byte, .m_time_first,
        .m_time_second, .m_last, .busy
    );

    `CFBU_ASSERT_IMP(a_time_not_last, aclk, aresetn, m_valid && m_out_kind == KIND_TIME, !m_last, "time set must be followed by ack")
    `CFBU_ASSERT_IMP(a_tx_clean, aclk, aresetn, m_valid && m_out_kind != KIND_TIME, m_time_first == 32'd0 && m_time_second == 32'd0, "time fields must be zero")
    `CFBU_ASSERT_NEXT(a_ack_follows, aclk, aresetn, m_valid && m_ready && m_out_kind == KIND_TIME, busy, "ack pending lost")
endmodule

@@ verif/crc_framed_batch_uplink_tb.sv @@
module crc_framed_batch_uplink_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cfbu_pkg::*;

    localparam int QS = 16;
    localparam int MB = 16;
    localparam int BM = 2;
    localparam int SETTLE_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        kind_t       kind;
        logic [7:0]  tx;
        logic [31:0] t1;
        logic [31:0] t2;
        logic        last;
    } uplink_result_t;

    class uplink_scoreboard;
        logic [7:0] store [QS*MB];
        int head, tail, fill, sync_cnt, timer, timeout_ticks;
        mode_t mode;
        logic [63:0] sync_val;
        uplink_result_t pending_results [$];
        int mismatches;

        function new();
            head = 0; tail = 0; fill = 0; sync_cnt = 0; timer = 0;
            timeout_ticks = 1000; mode = MODE_IDLE; sync_val = '0;
            mismatches = 0;
        endfunction

        function void add(ref uplink_result_t q[$], input kind_t k, input logic [7:0] tx,
                          input logic [31:0] a, input logic [31:0] b);
            uplink_result_t r;
            r.kind = k; r.tx = tx; r.t1 = a; r.t2 = b; r.last = 1'b0;
            q.push_back(r);
        endfunction

        function void run_batch(ref uplink_result_t q[$]);
            logic [7:0] payload [$];
            logic [15:0] crc;
            int len;
            int cnt;
            cnt = 0;
            while (cnt < BM && tail != head) begin
                for (int i = 0; i < MB; i++) payload.push_back(store[tail*MB + i]);
                tail = (tail + 1) % QS;
                cnt++;
            end
            if (cnt == 0) return;
            len = cnt * MB;
            crc = 16'hFFFF;
            foreach (payload[i]) begin
                crc = crc ^ {payload[i], 8'h00};
                for (int j = 0; j < 8; j++)
                    crc = crc[15] ? ({crc[14:0], 1'b0} ^ 16'h1021) : {crc[14:0], 1'b0};
            end
            add(q, KIND_TX, len[7:0], 0, 0);
            add(q, KIND_TX, len[15:8], 0, 0);
            add(q, KIND_TX, crc[7:0], 0, 0);
            add(q, KIND_TX, crc[15:8], 0, 0);
            foreach (payload[i]) add(q, KIND_TX, payload[i], 0, 0);
            mode = MODE_ACK;
            timer = timeout_ticks;
        endfunction

        function void note_input(req_t r, logic [7:0] d);
            uplink_result_t q [$];
            case (r)
                REQ_MSG: begin
                    store[head*MB + fill] = d;
                    fill++;
                    if (fill >= MB) begin
                        fill = 0;
                        if ((head + 1) % QS == tail) begin
                            add(q, KIND_DROP, 8'd0, 0, 0);
                        end else begin
                            head = (head + 1) % QS;
                            add(q, KIND_QUEUE, 8'd0, 0, 0);
                        end
                    end
                end
                REQ_HOST: begin
                    if (mode == MODE_SYNC) begin
                        sync_val[8*sync_cnt +: 8] = d;
                        sync_cnt++;
                        if (sync_cnt >= 8) begin
                            add(q, KIND_TIME, 8'd0, sync_val[31:0], sync_val[63:32]);
                            add(q, KIND_TX, HOST_ACK, 0, 0);
                            sync_cnt = 0; sync_val = '0; mode = MODE_IDLE;
                        end
                    end else if (mode == MODE_ACK) begin
                        if (d == HOST_ACK) begin
                            mode = MODE_IDLE; timer = 0;
                        end
                    end else if (d == HOST_SYNC) begin
                        mode = MODE_SYNC; sync_cnt = 0; sync_val = '0;
                    end else if (d == HOST_START) begin
                        run_batch(q);
                    end
                end
                REQ_TICK: begin
                    if (mode == MODE_ACK) begin
                        if (timer <= 1) begin
                            timer = 0; mode = MODE_IDLE;
                        end else begin
                            timer--;
                        end
                    end
                end
                default: ;
            endcase
            if (q.size() > 0) q[q.size()-1].last = 1'b1;
            foreach (q[i]) pending_results.push_back(q[i]);
        endfunction

        function void check_result(uplink_result_t got);
            uplink_result_t e;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result kind=%0d tx=%h", got.kind, got.tx);
                return;
            end
            e = pending_results.pop_front();
            if (e.kind != got.kind || e.tx != got.tx || e.t1 != got.t1 || e.t2 != got.t2
                || e.last != got.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: exp kind=%0d tx=%h t1=%h t2=%h last=%b, got kind=%0d tx=%h t1=%h t2=%h last=%b",
                             e.kind, e.tx, e.t1, e.t2, e.last,
                             got.kind, got.tx, got.t1, got.t2, got.last);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = '0;
    logic [7:0]  s_data_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_out_kind;
    logic [7:0]  m_tx_byte;
    logic [31:0] m_time_first;
    logic [31:0] m_time_second;
    logic        m_last;

    uplink_scoreboard sb = new();
    int idle_cycles = 0;
    int ready_hold = 0;
    int items_sent = 0;

    always #5 aclk = ~aclk;

    crc_framed_batch_uplink #(.QUEUE_SLOTS(QS), .MSG_BYTES(MB), .BATCH_MSGS(BM)) u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_data_byte(s_data_byte), .m_valid(m_valid), .m_ready(m_ready),
        .m_out_kind(m_out_kind), .m_tx_byte(m_tx_byte), .m_time_first(m_time_first),
        .m_time_second(m_time_second), .m_last(m_last)
    );

    // result side: random backpressure with long and short stalls
    always @(posedge aclk) begin
        if (ready_hold == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    m_ready <= 1'b1; ready_hold = $urandom_range(1, 40);
                end
                9: begin
                    m_ready <= 1'b0; ready_hold = $urandom_range(10, 30);
                end
                default: begin
                    m_ready <= 1'b0; ready_hold = $urandom_range(1, 3);
                end
            endcase
        end else begin
            ready_hold--;
        end
    end

    always @(posedge aclk) begin
        uplink_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.kind = kind_t'(m_out_kind);
            got.tx = m_tx_byte;
            got.t1 = m_time_first;
            got.t2 = m_time_second;
            got.last = m_last;
            sb.check_result(got);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_item(req_t r, logic [7:0] d);
        int gap;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: gap = 0;
            9: gap = $urandom_range(10, 40);
            default: gap = $urandom_range(1, 3);
        endcase
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= r;
        s_data_byte <= d;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(r, d);
        items_sent++;
    endtask

    task automatic send_message();
        for (int i = 0; i < MB; i++) send_item(REQ_MSG, 8'($urandom()));
    endtask

    task automatic send_sync();
        send_item(REQ_HOST, HOST_SYNC);
        for (int i = 0; i < 8; i++) send_item(REQ_HOST, 8'($urandom()));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_timeout(logic [15:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.timeout_ticks = v;
    endtask

    task automatic random_phase(int n_items);
        int start_count;
        start_count = items_sent;
        while (items_sent - start_count < n_items) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 16: send_message();
                7, 8, 9: send_sync();
                10, 11, 12, 13: begin
                    send_item(REQ_HOST, HOST_START);
                    repeat ($urandom_range(0, 3)) send_item(REQ_TICK, 8'($urandom()));
                    if ($urandom_range(0, 1)) send_item(REQ_HOST, 8'($urandom()));
                    if ($urandom_range(0, 2) != 0) send_item(REQ_HOST, HOST_ACK);
                end
                14, 15: repeat ($urandom_range(1, 4)) send_item(REQ_TICK, 8'($urandom()));
                default: send_item(req_t'($urandom_range(0, 3)), 8'($urandom()));
            endcase
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty-ring start, unused request, idle tick, junk host byte
        send_item(REQ_HOST, HOST_START);
        send_item(REQ_NONE, 8'hFF);
        send_item(REQ_TICK, 8'h00);
        send_item(REQ_HOST, 8'hAA);
        // sync data carrying command bytes, tick inside sync
        send_item(REQ_HOST, HOST_SYNC);
        send_item(REQ_HOST, HOST_START);
        send_item(REQ_HOST, HOST_SYNC);
        send_item(REQ_TICK, 8'h55);
        send_item(REQ_HOST, 8'hFF);
        send_item(REQ_HOST, 8'h00);
        send_item(REQ_HOST, 8'h80);
        send_item(REQ_HOST, 8'h01);
        send_item(REQ_HOST, 8'h7F);
        send_item(REQ_HOST, 8'hFE);
        for (int i = 0; i < MB; i++) send_item(REQ_MSG, (i % 2) ? 8'hFF : 8'h00);
        send_item(REQ_HOST, HOST_START);
        send_item(REQ_MSG, 8'h5A);
        send_item(REQ_HOST, 8'h33);
        send_item(REQ_HOST, HOST_ACK);

        write_timeout(16'd1000);
        random_phase(30);
        write_timeout(16'd1);
        random_phase(25);
        write_timeout(16'hFFFF);
        random_phase(20);
        write_timeout(16'd3);
        random_phase(20);

        wait_idle();
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+sv
sv/cfbu_pkg.sv
sv/cfbu_front.sv
sv/cfbu_back.sv
sv/crc_framed_batch_uplink.sv
verif/crc_framed_batch_uplink_tb.sv
